### rtl/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM        = 4;
  localparam int FRAC_BITS  = 16;
  localparam int STORE_SIZE = DIM * DIM;
  localparam int RC_W       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int IDX_W      = $clog2(STORE_SIZE);
  localparam int VAL_W      = 32;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = PROD_W + $clog2(DIM);

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic [3:0]              element_index;
    logic signed [VAL_W-1:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [3:0]              result_index;
    logic                    last_result;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Per-product tag carried down the MAC pipeline.
  typedef struct packed {
    logic             first_k;
    logic             last_k;
    logic [IDX_W-1:0] pos;
  } tag_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [IDX_W-1:0] addr_first;
    logic [IDX_W-1:0] addr_second;
  } issue_t;

  typedef struct packed {
    logic             en_first;
    logic             en_second;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } store_wr_t;

endpackage

### rtl/mm4_store.sv
module mm4_store (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mm4_pkg::store_wr_t                   wr,
  input  logic [mm4_pkg::IDX_W-1:0]            rd_addr_first,
  input  logic [mm4_pkg::IDX_W-1:0]            rd_addr_second,
  output logic signed [mm4_pkg::VAL_W-1:0]     rd_first,
  output logic signed [mm4_pkg::VAL_W-1:0]     rd_second
);

  logic [mm4_pkg::VAL_W-1:0] first_matrix  [mm4_pkg::STORE_SIZE];
  logic [mm4_pkg::VAL_W-1:0] second_matrix [mm4_pkg::STORE_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mm4_pkg::STORE_SIZE; i++) begin
        first_matrix[i]  <= '0;
        second_matrix[i] <= '0;
      end
    end else begin
      if (wr.en_first) begin
        first_matrix[wr.addr] <= wr.data;
      end
      if (wr.en_second) begin
        second_matrix[wr.addr] <= wr.data;
      end
    end
  end

  // Registered read, one address per store.
  always_ff @(posedge clk) begin
    rd_first  <= first_matrix[rd_addr_first];
    rd_second <= second_matrix[rd_addr_second];
  end

endmodule

### rtl/mm4_mac.sv
module mm4_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  mm4_pkg::issue_t                  issue,
  input  logic signed [mm4_pkg::VAL_W-1:0] opnd_first,
  input  logic signed [mm4_pkg::VAL_W-1:0] opnd_second,
  output logic                             result_strobe,
  output mm4_pkg::result_t                 result
);

  localparam logic signed [mm4_pkg::ACC_W-1:0] SAT_MAX =
    mm4_pkg::ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [mm4_pkg::ACC_W-1:0] SAT_MIN =
    mm4_pkg::ACC_W'(-64'sh0000_0000_8000_0000);

  // stage 1: operands arrive from store
  logic                                     v1;
  mm4_pkg::tag_t                            tag1;
  // stage 2: product
  logic                                     v2;
  mm4_pkg::tag_t                            tag2;
  logic signed [mm4_pkg::PROD_W-1:0]        prod;
  // stage 3: accumulator holds a finished sum
  logic                                     v3;
  logic [mm4_pkg::IDX_W-1:0]                pos3;
  logic signed [mm4_pkg::ACC_W-1:0]         acc;
  logic signed [mm4_pkg::ACC_W-1:0]         prod_ext;
  logic signed [mm4_pkg::ACC_W-1:0]         shifted;
  logic signed [mm4_pkg::VAL_W-1:0]         sat_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      v1            <= issue.valid;
      v2            <= v1;
      v3            <= v2 && tag2.last_k;
      result_strobe <= v3;
    end
  end

  assign prod_ext = mm4_pkg::ACC_W'(prod);
  assign shifted  = acc >>> mm4_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_value = 32'sh7FFF_FFFF;
    end else if (shifted < SAT_MIN) begin
      sat_value = -32'sh8000_0000;
    end else begin
      sat_value = shifted[mm4_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= issue.tag;
    tag2 <= tag1;
    prod <= opnd_first * opnd_second;
    if (v2) begin
      acc  <= tag2.first_k ? prod_ext : acc + prod_ext;
      pos3 <= tag2.pos;
    end
    result.result_value <= sat_value;
    result.result_index <= 4'(pos3);
    result.last_result  <= (int'(pos3) == mm4_pkg::STORE_SIZE - 1);
  end

endmodule

### rtl/mm4_ctrl.sv
module mm4_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  mm4_pkg::cmd_t         cmd,
  input  logic                  final_out,
  output logic                  busy,
  output mm4_pkg::store_wr_t    wr,
  output mm4_pkg::issue_t       issue
);

  mm4_pkg::state_t          state, state_next;
  logic [mm4_pkg::RC_W-1:0] row, col, kk;
  logic [mm4_pkg::RC_W-1:0] row_next, col_next, kk_next;
  logic                     accept;
  logic                     idx_ok;
  logic                     kk_end, col_end, row_end;

  assign busy    = (state != mm4_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign idx_ok  = int'(cmd.element_index) < mm4_pkg::STORE_SIZE;
  assign kk_end  = (int'(kk)  == mm4_pkg::DIM - 1);
  assign col_end = (int'(col) == mm4_pkg::DIM - 1);
  assign row_end = (int'(row) == mm4_pkg::DIM - 1);

  always_comb begin
    wr.en_first  = accept && idx_ok && (cmd.op == mm4_pkg::OP_LOAD_FIRST);
    wr.en_second = accept && idx_ok && (cmd.op == mm4_pkg::OP_LOAD_SECOND);
    wr.addr      = mm4_pkg::IDX_W'(cmd.element_index);
    wr.data      = cmd.element_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mm4_pkg::ST_IDLE;
      row   <= '0;
      col   <= '0;
      kk    <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      kk    <= kk_next;
    end
  end

  always_comb begin
    state_next      = state;
    row_next        = row;
    col_next        = col;
    kk_next         = kk;
    issue.valid     = 1'b0;
    issue.tag.first_k = (kk == '0);
    issue.tag.last_k  = kk_end;
    issue.tag.pos     = mm4_pkg::IDX_W'(int'(row) * mm4_pkg::DIM + int'(col));
    issue.addr_first  = mm4_pkg::IDX_W'(int'(row) * mm4_pkg::DIM + int'(kk));
    issue.addr_second = mm4_pkg::IDX_W'(int'(kk) * mm4_pkg::DIM + int'(col));
    case (state)
      mm4_pkg::ST_IDLE: begin
        row_next = '0;
        col_next = '0;
        kk_next  = '0;
        if (accept && cmd.op == mm4_pkg::OP_COMPUTE) begin
          state_next = mm4_pkg::ST_ISSUE;
        end
      end
      mm4_pkg::ST_ISSUE: begin
        issue.valid = 1'b1;
        if (kk_end) begin
          kk_next = '0;
          if (col_end) begin
            col_next = '0;
            if (row_end) begin
              row_next   = '0;
              state_next = mm4_pkg::ST_DRAIN;
            end else begin
              row_next = row + 1'b1;
            end
          end else begin
            col_next = col + 1'b1;
          end
        end else begin
          kk_next = kk + 1'b1;
        end
      end
      mm4_pkg::ST_DRAIN: begin
        if (final_out) begin
          state_next = mm4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mm4_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/matrix4x4_multiply_top.sv
// Channel | Handshake              | Payload               | Direction
// --------+------------------------+-----------------------+----------
// command | start high, busy low   | cmd (mm4_pkg::cmd_t)  | in
// result  | result_strobe, 1 cycle | result (result_t)     | out
//
// A load transaction writes its store directly; busy stays low, so loads may come
// back to back. A compute transaction keeps busy high until the final result
// goes out: the single multiply-accumulate unit takes one product per cycle,
// DIM^3 in all, through the read, multiply, accumulate and output stages.
// Each result leaves as its sum completes; the receiver cannot stall them.
// Synchronous reset clears both matrices to zero and returns to idle.
module matrix4x4_multiply_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mm4_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_strobe,
  output mm4_pkg::result_t result
);

  mm4_pkg::store_wr_t               wr;
  mm4_pkg::issue_t                  issue;
  logic signed [mm4_pkg::VAL_W-1:0] opnd_first;
  logic signed [mm4_pkg::VAL_W-1:0] opnd_second;
  logic                             final_out;

  // Sequencer drops back to idle as the flagged final element goes out.
  assign final_out = result_strobe && result.last_result;

  // Walks row, column and inner index; writes loads into the stores.
  mm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .final_out (final_out),
    .busy      (busy),
    .wr        (wr),
    .issue     (issue)
  );

  // Both matrices, register based, one registered read port each.
  mm4_store u_store (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .rd_addr_first  (issue.addr_first),
    .rd_addr_second (issue.addr_second),
    .rd_first       (opnd_first),
    .rd_second      (opnd_second)
  );

  // Shared 32x32 multiplier, wide accumulator, shift and saturate.
  mm4_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .issue         (issue),
    .opnd_first    (opnd_first),
    .opnd_second   (opnd_second),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
